>>> design/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants
// Kinds, status codes, register indexes, sequencer states, CORDIC table.
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_GOAL   = 2'd0,
        KIND_POSE   = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_CANCEL = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_RUNNING   = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_SUCCEEDED = 3'd3,
        ST_CANCELED  = 3'd4,
        ST_ABORTED   = 3'd5,
        ST_IGNORED   = 3'd6,
        ST_WAITING   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        REG_ARRIVE_TOL  = 3'd0,
        REG_DEADBAND    = 3'd1,
        REG_GAIN        = 3'd2,
        REG_MAX_TURN    = 3'd3,
        REG_ALIGN       = 3'd4,
        REG_MIN_SPEED   = 3'd5,
        REG_MAX_SPEED   = 3'd6,
        REG_TIMEOUT     = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_ITER,
        S_MAG,
        S_ERR,
        S_WRAP,
        S_TURN,
        S_OUT0,
        S_OUT1
    } seq_state_t;

    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    // CORDIC datapath width: 17-bit diff * 256 plus growth headroom
    localparam int CW = 28;
    localparam int ZW = 34;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sd843314857;
                5'd1:  r = 34'sd497837829;
                5'd2:  r = 34'sd263043837;
                5'd3:  r = 34'sd133525159;
                5'd4:  r = 34'sd67021687;
                5'd5:  r = 34'sd33543516;
                5'd6:  r = 34'sd16775851;
                5'd7:  r = 34'sd8388437;
                5'd8:  r = 34'sd4194283;
                5'd9:  r = 34'sd2097149;
                5'd10: r = 34'sd1048576;
                5'd11: r = 34'sd524288;
                5'd12: r = 34'sd262144;
                5'd13: r = 34'sd131072;
                5'd14: r = 34'sd65536;
                5'd15: r = 34'sd32768;
                5'd16: r = 34'sd16384;
                5'd17: r = 34'sd8192;
                5'd18: r = 34'sd4096;
                5'd19: r = 34'sd2048;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/gtp_stream_if.sv
// ----------------------------------------------------------------------------
// gtp_in_if / gtp_out_if: valid/ready channels
// Input item and result beat carriers with source and sink modports.
// ----------------------------------------------------------------------------
interface gtp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] waypoint_x;
    logic signed [15:0] waypoint_y;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [14:0] pose_heading;
    modport source (output valid, kind, waypoint_x, waypoint_y, pose_x, pose_y, pose_heading,
                    input ready);
    modport sink   (input valid, kind, waypoint_x, waypoint_y, pose_x, pose_y, pose_heading,
                    output ready);
endinterface

interface gtp_out_if;
    logic               valid;
    logic               ready;
    logic [14:0]        linear_speed;
    logic signed [15:0] turn_rate;
    logic [16:0]        distance;
    logic [2:0]         status;
    logic               last;
    modport source (output valid, linear_speed, turn_rate, distance, status, last,
                    input ready);
    modport sink   (input valid, linear_speed, turn_rate, distance, status, last,
                    output ready);
endinterface

>>> design/go_to_point_steering_controller.sv
// ----------------------------------------------------------------------------
// go_to_point_steering_controller: go-to-goal heading controller
// Q.FRAC_BITS steering of a unicycle robot toward a stored waypoint.
// ----------------------------------------------------------------------------
// Goal, cancel, idle-tick and pose-less tick beats load their result into
// the output register at the accepting edge, so it is offered in the next
// cycle; a pose beat gives no result. A control tick with a pose runs a setup
// state, then CORDIC_STEPS micro-rotations in the CORDIC vectoring unit (the
// last also starts the magnitude multiply), then magnitude rounding, the
// heading wrap, the gain multiply, the clamps and the output load, in that
// order. The block takes one item at a time; ready is high only in idle with
// the output register empty, so each item also waits for its last result beat
// to be taken, and an arrival gives a second (stop) beat after the first is
// taken. Configuration writes are registered.
module go_to_point_steering_controller #(
    parameter int FRAC_BITS    = 12,
    parameter int CORDIC_STEPS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gtp_in_if.sink                            in_ch,
    gtp_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gtp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [19:0] PI_Q = 20'((gtp_pkg::PI_Q30 + (34'sd1 <<< (SH-1))) >>> SH);
    localparam logic signed [19:0] TWO_PI_Q =
        20'((2 * gtp_pkg::PI_Q30 + (35'sd1 <<< (SH-1))) >>> SH);
    localparam longint LIM_RAW = (64'sd32 <<< FRAC_BITS) - 1;
    localparam logic [16:0] DIST_LIM = (LIM_RAW > 131071) ? 17'd131071 : 17'(LIM_RAW);

    // configuration registers
    logic [15:0] arrive_tol_reg, deadband_reg, gain_reg;
    logic [14:0] max_turn_reg, min_speed_reg, max_speed_reg;
    logic [13:0] align_reg;
    logic [7:0]  timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrive_tol_reg <= 16'd410;
            deadband_reg   <= 16'd205;
            gain_reg       <= 16'd16384;
            max_turn_reg   <= 15'd8192;
            align_reg      <= 14'd410;
            min_speed_reg  <= 15'd819;
            max_speed_reg  <= 15'd8192;
            timeout_reg    <= 8'd40;
        end
        else if (cfg_we)
        begin
            unique case (gtp_pkg::reg_idx_t'(cfg_index))
                gtp_pkg::REG_ARRIVE_TOL: arrive_tol_reg <= cfg_data;
                gtp_pkg::REG_DEADBAND:   deadband_reg   <= cfg_data;
                gtp_pkg::REG_GAIN:       gain_reg       <= cfg_data;
                gtp_pkg::REG_MAX_TURN:   max_turn_reg   <= cfg_data[14:0];
                gtp_pkg::REG_ALIGN:      align_reg      <= cfg_data[13:0];
                gtp_pkg::REG_MIN_SPEED:  min_speed_reg  <= cfg_data[14:0];
                gtp_pkg::REG_MAX_SPEED:  max_speed_reg  <= cfg_data[14:0];
                gtp_pkg::REG_TIMEOUT:    timeout_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // controller state
    gtp_pkg::seq_state_t state_reg, state_next;
    logic busy_reg, busy_next, seen_reg, seen_next;
    logic [7:0] wait_reg, wait_next;
    logic signed [15:0] gx_reg, gx_next, gy_reg, gy_next, rx_reg, rx_next, ry_reg, ry_next;
    logic signed [14:0] rh_reg, rh_next;

    // datapath registers
    logic signed [47:0] prod_reg, prod_next;   // shared multiplier result
    logic [16:0] dist_reg, dist_next;
    logic signed [19:0] err_reg, err_next;
    logic signed [15:0] turn_reg, turn_next;
    logic [14:0] lin_reg, lin_next;
    logic arrive_reg, arrive_next;

    // output register
    logic ov_reg, ov_next;
    logic [14:0] olin_reg, olin_next;
    logic signed [15:0] oturn_reg, oturn_next;
    logic [16:0] odist_reg, odist_next;
    gtp_pkg::status_t ost_reg, ost_next;
    logic olast_reg, olast_next;

    logic cstart, cdone;
    logic signed [gtp_pkg::CW-1:0] cx;
    logic signed [gtp_pkg::ZW-1:0] cz;
    logic signed [16:0] dx, dy;

    assign dx = 17'(gx_reg) - 17'(rx_reg);
    assign dy = 17'(gy_reg) - 17'(ry_reg);

    gtp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart), .dx(dx), .dy(dy),
        .done(cdone), .x_out(cx), .z_out(cz)
    );

    logic in_fire, out_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == gtp_pkg::S_IDLE) && !ov_reg;

    logic signed [47:0] mag_sh, ang_r, turn_r, mul_a, mul_b;
    logic mul_en;
    logic [7:0] wait_inc;
    logic signed [19:0] abs_err;
    logic signed [16:0] mt_s;

    always_comb
    begin
        state_next = state_reg;
        busy_next = busy_reg; seen_next = seen_reg; wait_next = wait_reg;
        gx_next = gx_reg; gy_next = gy_reg; rx_next = rx_reg; ry_next = ry_reg;
        rh_next = rh_reg;
        prod_next = prod_reg; dist_next = dist_reg; err_next = err_reg;
        turn_next = turn_reg; lin_next = lin_reg; arrive_next = arrive_reg;
        ov_next = ov_reg && !out_fire;
        olin_next = olin_reg; oturn_next = oturn_reg; odist_next = odist_reg;
        ost_next = ost_reg; olast_next = olast_reg;
        cstart = 1'b0;
        wait_inc = (wait_reg == 8'd255) ? wait_reg : wait_reg + 8'd1;
        mul_a = '0; mul_b = '0; mul_en = 1'b0;
        mag_sh = '0; ang_r = '0; turn_r = '0;
        abs_err = (err_reg < 0) ? -err_reg : err_reg;
        mt_s = 17'(max_turn_reg);

        unique case (state_reg)
            gtp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    olin_next = '0; oturn_next = '0; odist_next = '0; olast_next = 1'b1;
                    unique case (gtp_pkg::kind_t'(in_ch.kind))
                        gtp_pkg::KIND_POSE:
                        begin
                            rx_next = in_ch.pose_x; ry_next = in_ch.pose_y;
                            rh_next = in_ch.pose_heading; seen_next = 1'b1;
                        end
                        gtp_pkg::KIND_GOAL:
                        begin
                            ov_next = 1'b1;
                            if (busy_reg)
                                ost_next = gtp_pkg::ST_REJECTED;
                            else
                            begin
                                gx_next = in_ch.waypoint_x; gy_next = in_ch.waypoint_y;
                                busy_next = 1'b1; wait_next = '0;
                                ost_next = gtp_pkg::ST_ACCEPTED;
                            end
                        end
                        gtp_pkg::KIND_CANCEL:
                        begin
                            ov_next = 1'b1;
                            ost_next = busy_reg ? gtp_pkg::ST_CANCELED : gtp_pkg::ST_IGNORED;
                            busy_next = 1'b0;
                        end
                        default:
                        begin
                            if (!busy_reg)
                            begin
                                ov_next = 1'b1; ost_next = gtp_pkg::ST_IGNORED;
                            end
                            else if (!seen_reg)
                            begin
                                ov_next = 1'b1; wait_next = wait_inc;
                                if (wait_inc >= timeout_reg)
                                begin
                                    busy_next = 1'b0; ost_next = gtp_pkg::ST_ABORTED;
                                end
                                else
                                    ost_next = gtp_pkg::ST_WAITING;
                            end
                            else
                                state_next = gtp_pkg::S_PRE;
                        end
                    endcase
                end
            end
            gtp_pkg::S_PRE:
            begin
                cstart = 1'b1;
                state_next = gtp_pkg::S_ITER;
            end
            gtp_pkg::S_ITER:
            begin
                if (cdone)
                begin
                    // rounded angle in Q.FRAC_BITS minus heading
                    ang_r = 48'(cz) + (48'sd1 <<< (SH-1));
                    err_next = 20'(ang_r >>> SH) - 20'(rh_reg);
                    mul_a = 48'(cx); mul_b = 48'(gtp_pkg::INV_GAIN_Q16);
                    mul_en = 1'b1;
                    state_next = gtp_pkg::S_MAG;
                end
            end
            gtp_pkg::S_MAG:
            begin
                mag_sh = (prod_reg + 48'sd8388608) >>> 24;
                dist_next = (mag_sh > 48'(DIST_LIM)) ? DIST_LIM : 17'(mag_sh);
                state_next = gtp_pkg::S_WRAP;
            end
            gtp_pkg::S_WRAP:
            begin
                // heading in range keeps the error within one wrap
                if (err_reg > PI_Q)
                    err_next = err_reg - TWO_PI_Q;
                else if (err_reg < -PI_Q)
                    err_next = err_reg + TWO_PI_Q;
                if (err_next > PI_Q || err_next < -PI_Q)
                    state_next = gtp_pkg::S_WRAP;
                else
                    state_next = gtp_pkg::S_ERR;
            end
            gtp_pkg::S_ERR:
            begin
                mul_a = 48'(err_reg); mul_b = 48'(gain_reg);
                mul_en = 1'b1;
                state_next = gtp_pkg::S_TURN;
            end
            gtp_pkg::S_TURN:
            begin
                turn_r = (prod_reg + (48'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
                turn_next = '0; lin_next = '0;
                if (dist_reg > 17'(deadband_reg))
                begin
                    if (turn_r > 48'(mt_s)) turn_next = 16'(mt_s);
                    else if (turn_r < -48'(mt_s)) turn_next = -16'(mt_s);
                    else turn_next = 16'(turn_r);
                    if (abs_err < 20'(align_reg))
                    begin
                        if (dist_reg < 17'(min_speed_reg)) lin_next = min_speed_reg;
                        else if (dist_reg > 17'(max_speed_reg)) lin_next = max_speed_reg;
                        else lin_next = 15'(dist_reg);
                        if (lin_next > max_speed_reg) lin_next = max_speed_reg;
                    end
                end
                arrive_next = dist_reg < 17'(arrive_tol_reg);
                state_next = gtp_pkg::S_OUT0;
            end
            gtp_pkg::S_OUT0:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    olin_next = lin_reg; oturn_next = turn_reg; odist_next = dist_reg;
                    ost_next = gtp_pkg::ST_RUNNING; olast_next = !arrive_reg;
                    state_next = arrive_reg ? gtp_pkg::S_OUT1 : gtp_pkg::S_IDLE;
                end
            end
            gtp_pkg::S_OUT1:
            begin
                if (!ov_reg || out_fire)
                begin
                    ov_next = 1'b1;
                    olin_next = '0; oturn_next = '0; odist_next = dist_reg;
                    ost_next = gtp_pkg::ST_SUCCEEDED; olast_next = 1'b1;
                    busy_next = 1'b0;
                    state_next = gtp_pkg::S_IDLE;
                end
            end
            default: state_next = gtp_pkg::S_IDLE;
        endcase

        // one multiplier shared by the magnitude and gain steps
        if (mul_en)
            prod_next = 48'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtp_pkg::S_IDLE;
            busy_reg <= 1'b0; seen_reg <= 1'b0; wait_reg <= '0;
            gx_reg <= '0; gy_reg <= '0; rx_reg <= '0; ry_reg <= '0; rh_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next; seen_reg <= seen_next; wait_reg <= wait_next;
            gx_reg <= gx_next; gy_reg <= gy_next; rx_reg <= rx_next; ry_reg <= ry_next;
            rh_reg <= rh_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next; dist_reg <= dist_next; err_reg <= err_next;
        turn_reg <= turn_next; lin_reg <= lin_next; arrive_reg <= arrive_next;
        olin_reg <= olin_next; oturn_reg <= oturn_next; odist_reg <= odist_next;
        ost_reg <= ost_next; olast_reg <= olast_next;
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.linear_speed = olin_reg;
    assign out_ch.turn_rate    = oturn_reg;
    assign out_ch.distance     = odist_reg;
    assign out_ch.status       = ost_reg;
    assign out_ch.last         = olast_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == gtp_pkg::S_IDLE)
        else $error("ready outside idle");
    a_stop_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && ost_reg == gtp_pkg::ST_RUNNING && !olast_reg) |=>
            (out_ch.valid && out_ch.status == gtp_pkg::ST_SUCCEEDED))
        else $error("stop beat missing after arrival");
    a_turn_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gtp_pkg::S_OUT0 |->
            (turn_reg <= 16'(mt_s) && turn_reg >= -16'(mt_s)))
        else $error("turn rate beyond clamp");
`endif
endmodule

>>> design/gtp_cordic.sv
// ----------------------------------------------------------------------------
// gtp_cordic: iterative CORDIC vectoring unit
// One micro-rotation per cycle; one shift-add pair and one angle add shared.
// ----------------------------------------------------------------------------
module gtp_cordic #(
    parameter int STEPS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [16:0]             dx,
    input  logic signed [16:0]             dy,
    output logic                           done,
    output logic signed [gtp_pkg::CW-1:0]  x_out,
    output logic signed [gtp_pkg::ZW-1:0]  z_out
);
    localparam int IW = $clog2(STEPS + 1);

    logic signed [gtp_pkg::CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [gtp_pkg::ZW-1:0] z_reg, z_next;
    logic [IW-1:0] i_reg, i_next;
    logic busy_reg, busy_next;
    logic signed [gtp_pkg::CW-1:0] px, py, xs, ys;

    always_comb
    begin
        px = gtp_pkg::CW'(dx) <<< 8;
        py = gtp_pkg::CW'(dy) <<< 8;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        if (start)
        begin
            i_next = '0;
            busy_next = (STEPS > 0);
            if (px < 0)
            begin
                if (py >= 0)
                begin
                    x_next = py; y_next = -px; z_next = gtp_pkg::HALF_PI_Q30;
                end
                else
                begin
                    x_next = -py; y_next = px; z_next = -gtp_pkg::HALF_PI_Q30;
                end
            end
            else
            begin
                x_next = px; y_next = py; z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + gtp_pkg::atan_q30(5'(i_reg));
            end
            else
            begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - gtp_pkg::atan_q30(5'(i_reg));
            end
            i_next = i_reg + 1'b1;
            if (i_reg == IW'(STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = busy_reg && !busy_next;
    assign x_out = x_next;
    assign z_out = z_next;
endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: go-to-point steering controller testbench
// Drives goal, pose, tick and cancel beats under random stalls and checks
// every result beat against a scoreboard that predicts the controller.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        gtp_pkg::kind_t     kind;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [14:0] ph;
    } cmd_t;

    typedef struct {
        logic [14:0]        lin;
        logic signed [15:0] turn;
        logic [16:0]        dlen;
        logic [2:0]         st;
        logic               last;
    } beat_t;

    // Steering predictor plus the queue of beats it still owes.
    class gtp_scoreboard;
        int unsigned regs[8];
        bit          busy;
        bit          seen;
        longint      gx, gy, rx, ry, rh;
        int unsigned waits;
        beat_t       owed_q[$];
        int          errors;
        longint      atan_tab[14];

        function new();
            regs = '{410, 205, 16384, 8192, 410, 819, 8192, 40};
            atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149,
                         1048576, 524288, 262144, 131072};
            busy = 0; seen = 0; gx = 0; gy = 0; rx = 0; ry = 0; rh = 0;
            waits = 0; errors = 0;
        endfunction

        function void set_reg(gtp_pkg::reg_idx_t idx, int unsigned v);
            int unsigned w[8];
            w = '{16, 16, 16, 15, 14, 15, 15, 8};
            regs[idx] = v & ((1 << w[idx]) - 1);
        endfunction

        function void owe(longint lin, longint turn, longint dst, gtp_pkg::status_t st,
                          bit last);
            beat_t b;
            b.lin = lin[14:0]; b.turn = turn[15:0]; b.dlen = dst[16:0];
            b.st = st; b.last = last;
            owed_q.push_back(b);
        endfunction

        function void steer();
            longint pi_q, two_pi_q, x, y, z, t, xs, ys, mag, dst_q, err, aerr;
            longint turn, lin, mt, lo, hi;
            pi_q = (64'sd3373259426 + (1 << 17)) >>> 18;
            two_pi_q = (64'sd6746518852 + (1 << 17)) >>> 18;
            mt = longint'(regs[gtp_pkg::REG_MAX_TURN]);
            lo = longint'(regs[gtp_pkg::REG_MIN_SPEED]);
            hi = longint'(regs[gtp_pkg::REG_MAX_SPEED]);
            x = (gx - rx) * 256;
            y = (gy - ry) * 256;
            z = 0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = 64'sd1686629713;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -64'sd1686629713;
                end
            end
            for (int i = 0; i < 14; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x += ys; y -= xs; z += atan_tab[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
            end
            mag = (x * 39797 + (1 << 23)) >>> 24;
            dst_q = mag > 131071 ? 131071 : mag;
            err = ((z + (1 << 17)) >>> 18) - rh;
            while (err > pi_q) err -= two_pi_q;
            while (err < -pi_q) err += two_pi_q;
            turn = 0;
            lin = 0;
            if (dst_q > longint'(regs[gtp_pkg::REG_DEADBAND]))
            begin
                aerr = err < 0 ? -err : err;
                turn = (err * longint'(regs[gtp_pkg::REG_GAIN]) + 2048) >>> 12;
                if (turn > mt) turn = mt;
                if (turn < -mt) turn = -mt;
                if (aerr < longint'(regs[gtp_pkg::REG_ALIGN]))
                begin
                    lin = dst_q < lo ? lo : dst_q;
                    if (lin > hi) lin = hi;
                end
            end
            if (dst_q < longint'(regs[gtp_pkg::REG_ARRIVE_TOL]))
            begin
                owe(lin, turn, dst_q, gtp_pkg::ST_RUNNING, 0);
                owe(0, 0, dst_q, gtp_pkg::ST_SUCCEEDED, 1);
                busy = 0;
            end
            else
            begin
                owe(lin, turn, dst_q, gtp_pkg::ST_RUNNING, 1);
            end
        endfunction

        function void note(cmd_t c);
            case (c.kind)
                gtp_pkg::KIND_POSE:
                begin
                    rx = c.px; ry = c.py; rh = c.ph; seen = 1;
                end
                gtp_pkg::KIND_GOAL:
                begin
                    if (busy) owe(0, 0, 0, gtp_pkg::ST_REJECTED, 1);
                    else
                    begin
                        gx = c.tx; gy = c.ty; busy = 1; waits = 0;
                        owe(0, 0, 0, gtp_pkg::ST_ACCEPTED, 1);
                    end
                end
                default:
                begin
                    if (!busy) owe(0, 0, 0, gtp_pkg::ST_IGNORED, 1);
                    else if (c.kind == gtp_pkg::KIND_CANCEL)
                    begin
                        busy = 0;
                        owe(0, 0, 0, gtp_pkg::ST_CANCELED, 1);
                    end
                    else if (!seen)
                    begin
                        if (waits < 255) waits++;
                        if (waits >= regs[gtp_pkg::REG_TIMEOUT])
                        begin
                            busy = 0;
                            owe(0, 0, 0, gtp_pkg::ST_ABORTED, 1);
                        end
                        else owe(0, 0, 0, gtp_pkg::ST_WAITING, 1);
                    end
                    else steer();
                end
            endcase
        endfunction

        function void check(beat_t got);
            beat_t exp_b;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result beat: status %0d", got.st);
                errors++;
                return;
            end
            exp_b = owed_q.pop_front();
            if (got.lin !== exp_b.lin)
            begin
                $error("linear_speed: expected %0d, got %0d", exp_b.lin, got.lin); errors++;
            end
            if (got.turn !== exp_b.turn)
            begin
                $error("turn_rate: expected %0d, got %0d", exp_b.turn, got.turn); errors++;
            end
            if (got.dlen !== exp_b.dlen)
            begin
                $error("distance: expected %0d, got %0d", exp_b.dlen, got.dlen); errors++;
            end
            if (got.st !== exp_b.st)
            begin
                $error("status: expected %0d, got %0d", exp_b.st, got.st); errors++;
            end
            if (got.last !== exp_b.last)
            begin
                $error("last: expected %0d, got %0d", exp_b.last, got.last); errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [gtp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gtp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    gtp_in_if  in_ch ();
    gtp_out_if out_ch ();

    gtp_scoreboard sb = new();

    // 0: sender rarely idles, receiver mostly stalls; 1: the reverse; 2: no idling
    int idle_mode = 0;
    int sent = 0;

    always #2 clk = ~clk;

    go_to_point_steering_controller u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Result side: check each accepted beat, then pick next cycle's ready.
    always @(posedge clk)
    begin
        beat_t b;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            b.lin = out_ch.linear_speed; b.turn = out_ch.turn_rate;
            b.dlen = out_ch.distance; b.st = out_ch.status; b.last = out_ch.last;
            sb.check(b);
        end
        case (idle_mode)
            0:       out_ch.ready <= ($urandom_range(99) >= 75);
            1:       out_ch.ready <= ($urandom_range(99) >= 9);
            default: out_ch.ready <= 1'b1;
        endcase
    end

    // Present one item, hold it until the handshake, then log it as accepted.
    task automatic send(cmd_t c);
        int pct;
        pct = (idle_mode == 0) ? 9 : (idle_mode == 1) ? 75 : 0;
        if ($urandom_range(99) < pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < pct) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= c.kind;
        in_ch.waypoint_x <= c.tx;
        in_ch.waypoint_y <= c.ty;
        in_ch.pose_x <= c.px;
        in_ch.pose_y <= c.py;
        in_ch.pose_heading <= c.ph;
        do @(posedge clk); while (!in_ch.ready);
        sb.note(c);
        sent++;
        if (sent == 283) idle_mode = 1;
        if (sent == 566) idle_mode = 2;
    endtask

    task automatic mk(gtp_pkg::kind_t k, int tx, int ty, int px, int py, int ph);
        cmd_t c;
        c.kind = k; c.tx = 16'(tx); c.ty = 16'(ty); c.px = 16'(px); c.py = 16'(py);
        c.ph = 15'(ph);
        send(c);
    endtask

    // Drain all owed beats, then let a pose beat in flight settle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_regs(int unsigned v[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= 16'(v[i]);
            sb.set_reg(gtp_pkg::reg_idx_t'(i), v[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int near(int base, int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic int rand_heading();
        if ($urandom_range(9) == 0) return int'($signed(15'($urandom)));
        return int'($urandom_range(25736)) - 12868;
    endfunction

    // One goal run: mostly poses around the waypoint and ticks, a little noise.
    task automatic goal_run();
        int tx, ty, spread, n, r;
        tx = int'($signed(16'($urandom)));
        ty = int'($signed(16'($urandom)));
        if ($urandom_range(3) == 0)
        begin
            tx = tx / 8; ty = ty / 8;
        end
        mk(gtp_pkg::KIND_GOAL, tx, ty, $urandom, $urandom, 0);
        n = 0;
        while (sb.busy && n < 30)
        begin
            r = $urandom_range(99);
            case ($urandom_range(3))
                0: spread = 200;
                1: spread = 1500;
                2: spread = 12000;
                default: spread = 65535;
            endcase
            if (r < 35)
                mk(gtp_pkg::KIND_POSE, $urandom, $urandom, near(tx, spread),
                   near(ty, spread), rand_heading());
            else if (r < 85)
                mk(gtp_pkg::KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 90)
                mk(gtp_pkg::KIND_CANCEL, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                mk(gtp_pkg::kind_t'($urandom_range(3)), $urandom, $urandom, $urandom,
                   $urandom, $urandom);
            n++;
        end
    endtask

    initial
    begin
        int unsigned v[8];
        in_ch.valid = 1'b0;
        in_ch.kind = gtp_pkg::KIND_GOAL;
        in_ch.waypoint_x = '0; in_ch.waypoint_y = '0;
        in_ch.pose_x = '0; in_ch.pose_y = '0; in_ch.pose_heading = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short pose timeout so the abort path is reached before any pose arrives.
        v = '{410, 205, 16384, 8192, 410, 819, 8192, 2};
        write_regs(v);
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);           // idle tick: ignored
        mk(gtp_pkg::KIND_CANCEL, 0, 0, 0, 0, 0);         // idle cancel: ignored
        mk(gtp_pkg::KIND_GOAL, 100, 200, 0, 0, 0);       // accepted
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);           // waiting
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);           // timeout: aborted
        mk(gtp_pkg::KIND_GOAL, -32768, 32767, 0, 0, 0);
        mk(gtp_pkg::KIND_GOAL, 5, 5, 0, 0, 0);           // rejected while busy
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);           // waiting
        mk(gtp_pkg::KIND_CANCEL, 0, 0, 0, 0, 0);         // canceled
        mk(gtp_pkg::KIND_GOAL, -32768, 32767, 0, 0, 0);
        mk(gtp_pkg::KIND_POSE, 0, 0, 32767, -32768, 12868);
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);           // largest possible distance
        mk(gtp_pkg::KIND_POSE, 0, 0, -32768, 32767, -12868);
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);           // on goal: running then succeeded
        mk(gtp_pkg::KIND_GOAL, 3000, -3000, 0, 0, 0);
        mk(gtp_pkg::KIND_POSE, 0, 0, 3100, -3050, -16384);   // heading outside +-pi
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);           // inside deadband: zero commands
        mk(gtp_pkg::KIND_POSE, 0, 0, 0, 0, 16383);
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);
        mk(gtp_pkg::KIND_POSE, 0, 0, 0, 0, -7854);
        mk(gtp_pkg::KIND_TICK, 0, 0, 0, 0, 0);
        mk(gtp_pkg::KIND_CANCEL, 0, 0, 0, 0, 0);
        settle();

        // Register sweeps: defaults, all minimum, all maximum, a fixed mix, then random.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: v = '{410, 205, 16384, 8192, 410, 819, 8192, 40};
                1: v = '{0, 0, 0, 0, 0, 0, 0, 1};
                2: v = '{65535, 65535, 65535, 32767, 12868, 32767, 32767, 255};
                3: v = '{2000, 100, 65535, 32767, 12868, 0, 32767, 1};
                default: v = '{$urandom_range(4000), $urandom_range(1000),
                               $urandom_range(65535), $urandom_range(32767),
                               $urandom_range(12868), $urandom_range(4000),
                               $urandom_range(32767), $urandom_range(255, 1)};
            endcase
            write_regs(v);
            while (sent < 22 + (ph + 1) * 138) goal_run();
            settle();
        end

        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/gtp_pkg.sv
design/gtp_stream_if.sv
design/gtp_cordic.sv
design/go_to_point_steering_controller.sv
tb/tb.sv
